FILE: rtl/dual_rc_pulse_width_capture_assert.svh
// Assertion macros used by the checker file.
`ifndef DUAL_RC_PULSE_WIDTH_CAPTURE_ASSERT_SVH
`define DUAL_RC_PULSE_WIDTH_CAPTURE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define DRPWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drpwc assertion failed");

// Next-cycle implication, masked during reset.
`define DRPWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drpwc assertion failed");

// Next-cycle implication that also checks across reset.
`define DRPWC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("drpwc assertion failed");

`endif

FILE: rtl/drpwc_pkg.sv
package drpwc_pkg;

  localparam int WIDTH_BITS_DEF = 16;
  localparam int OUT_WIDTH_BITS = 16;
  localparam int AGE_BITS = 24;

  localparam logic [OUT_WIDTH_BITS-1:0] RESET_WIDTH = 16'd1500;
  localparam logic [AGE_BITS-1:0] AGE_MAX = 24'hFFFFFF;
  localparam logic [AGE_BITS-1:0] FAIL_SAFE_RESET = 24'd100000;

  typedef struct packed {
    logic ch1_level;
    logic ch2_level;
  } in_word_t;

  typedef struct packed {
    logic [OUT_WIDTH_BITS-1:0] width_ch1;
    logic [OUT_WIDTH_BITS-1:0] width_ch2;
    logic                      capture_done;
    logic                      done_channel;
    logic                      fail_safe;
  } out_word_t;

  // Capture event of the word under work, phase machine to age tracker.
  typedef struct packed {
    logic done;
    logic channel;
  } capture_t;

endpackage

FILE: rtl/drpwc_phase.sv
module drpwc_phase #(
  parameter int WIDTH_BITS = drpwc_pkg::WIDTH_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  drpwc_pkg::in_word_t                   word,
  output logic [drpwc_pkg::OUT_WIDTH_BITS-1:0]  width_ch1_next,
  output logic [drpwc_pkg::OUT_WIDTH_BITS-1:0]  width_ch2_next,
  output drpwc_pkg::capture_t                   capture
);
  import drpwc_pkg::*;

  typedef enum logic [1:0] {
    WAIT_CH1,
    HIGH_CH1,
    WAIT_CH2,
    HIGH_CH2
  } phase_t;

  localparam logic [WIDTH_BITS-1:0] COUNT_MAX = {WIDTH_BITS{1'b1}};
  localparam logic [WIDTH_BITS-1:0] COUNT_ONE = WIDTH_BITS'(1);

  phase_t                    phase, phase_next;
  logic [1:0]                prev_levels;
  logic [WIDTH_BITS-1:0]     pulse_counter, pulse_counter_next, counter_bumped;
  logic [OUT_WIDTH_BITS-1:0] width_ch1, width_ch2;

  assign counter_bumped = (pulse_counter == COUNT_MAX) ? COUNT_MAX
                                                       : pulse_counter + COUNT_ONE;

  always_comb begin
    phase_next         = phase;
    pulse_counter_next = pulse_counter;
    width_ch1_next     = width_ch1;
    width_ch2_next     = width_ch2;
    capture            = '0;
    case (phase)
      WAIT_CH1: begin
        if (word.ch1_level && !prev_levels[0]) begin
          pulse_counter_next = COUNT_ONE;
          phase_next         = HIGH_CH1;
        end
      end
      HIGH_CH1: begin
        if (!word.ch1_level && prev_levels[0]) begin
          width_ch1_next = OUT_WIDTH_BITS'(pulse_counter);
          capture.done   = 1'b1;
          phase_next     = WAIT_CH2;
        end else begin
          pulse_counter_next = counter_bumped;
        end
      end
      WAIT_CH2: begin
        if (word.ch2_level && !prev_levels[1]) begin
          pulse_counter_next = COUNT_ONE;
          phase_next         = HIGH_CH2;
        end
      end
      HIGH_CH2: begin
        if (!word.ch2_level && prev_levels[1]) begin
          width_ch2_next  = OUT_WIDTH_BITS'(pulse_counter);
          capture.done    = 1'b1;
          capture.channel = 1'b1;
          phase_next      = WAIT_CH1;
        end else begin
          pulse_counter_next = counter_bumped;
        end
      end
      default: begin
        phase_next = WAIT_CH1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= WAIT_CH1;
      prev_levels   <= '0;
      pulse_counter <= '0;
      width_ch1     <= RESET_WIDTH;
      width_ch2     <= RESET_WIDTH;
    end else if (advance) begin
      phase         <= phase_next;
      prev_levels   <= {word.ch2_level, word.ch1_level};
      pulse_counter <= pulse_counter_next;
      width_ch1     <= width_ch1_next;
      width_ch2     <= width_ch2_next;
    end
  end

endmodule

FILE: rtl/drpwc_age.sv
module drpwc_age (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  drpwc_pkg::capture_t             capture,
  input  logic                            cfg_write,
  input  logic [drpwc_pkg::AGE_BITS-1:0]  cfg_data,
  output logic                            fail_safe_next
);
  import drpwc_pkg::*;

  logic [AGE_BITS-1:0] fail_safe_ticks;
  logic [AGE_BITS-1:0] capture_age, capture_age_next;

  always_comb begin
    if (capture.done) begin
      capture_age_next = '0;
    end else if (capture_age != AGE_MAX) begin
      capture_age_next = capture_age + AGE_BITS'(1);
    end else begin
      capture_age_next = capture_age;
    end
  end

  assign fail_safe_next = capture_age_next > fail_safe_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_safe_ticks <= FAIL_SAFE_RESET;
    end else if (cfg_write) begin
      fail_safe_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_age <= '0;
    end else if (advance) begin
      capture_age <= capture_age_next;
    end
  end

endmodule

FILE: rtl/dual_rc_pulse_width_capture.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------
// in       | input     | in_valid / in_stall  | in_data  (ch1/ch2 pin levels)
// out      | output    | out_valid / out_stall| out_data (widths, done, fail)
// cfg      | input     | cfg_write            | cfg_data (fail_safe_ticks)
//
// One word is taken every cycle while in_stall is low; the input register takes
// it when it is accepted and the result register takes it from there, so its
// result word shows once it has passed through both registers.
// The phase machine, shared pulse counter and age counter are all one-step
// updates, so the result register is the only thing that paces the block.
// rst is synchronous: phase to wait for channel 1, widths to 1500, age to 0,
// fail_safe_ticks to 100000, both registers empty.
// out_stall holds the result word; an empty input register still takes one
// more word before in_stall rises.
module dual_rc_pulse_width_capture #(
  parameter int WIDTH_BITS = drpwc_pkg::WIDTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  drpwc_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output drpwc_pkg::out_word_t            out_data,
  input  logic                            cfg_write,
  input  logic [drpwc_pkg::AGE_BITS-1:0]  cfg_data
);
  import drpwc_pkg::*;

  // Input register.
  logic     s1_valid;
  in_word_t s1_data;

  // Handshake control.
  logic out_free;   // result register can take a new word this cycle
  logic advance;    // input register word moves into the result register
  logic accept;

  // Combinational results of the word in the input register.
  logic [OUT_WIDTH_BITS-1:0] width_ch1_next, width_ch2_next;
  capture_t                  capture;
  logic                      fail_safe_next;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // Phase machine: edge detect, shared counter, held widths.
  drpwc_phase #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_phase (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .word           (s1_data),
    .width_ch1_next (width_ch1_next),
    .width_ch2_next (width_ch2_next),
    .capture        (capture)
  );

  // Age since last capture and the fail-safe compare.
  drpwc_age u_age (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .capture        (capture),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .fail_safe_next (fail_safe_next)
  );

  // Valid bits: refill the input register whenever it is not held, load the
  // result register whenever it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= advance;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data.width_ch1    <= width_ch1_next;
      out_data.width_ch2    <= width_ch2_next;
      out_data.capture_done <= capture.done;
      out_data.done_channel <= capture.channel;
      out_data.fail_safe    <= fail_safe_next;
    end
  end

endmodule

FILE: rtl/drpwc_check.sv
`include "dual_rc_pulse_width_capture_assert.svh"

module drpwc_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input drpwc_pkg::in_word_t             in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input drpwc_pkg::out_word_t            out_data
);

  // A stalled input word holds.
  `DRPWC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // A stalled result word holds.
  `DRPWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Channel flag is clear on a word without a capture.
  `DRPWC_ASSERT_NOW(a_chan_idle, out_valid && !out_data.capture_done, !out_data.done_channel)

  // A capture restarts the age, so fail-safe cannot show with it.
  `DRPWC_ASSERT_NOW(a_fail_clear, out_valid && out_data.capture_done, !out_data.fail_safe)

  // Reset empties the result register.
  `DRPWC_ASSERT_RST(a_rst_empty, rst, !out_valid)

endmodule

bind dual_rc_pulse_width_capture drpwc_check u_check (.*);

FILE: tb/dual_rc_pulse_width_capture_tb.sv
module dual_rc_pulse_width_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drpwc_pkg::*;

  // Counter width of the instance under test (default parameter).
  localparam int CNT_BITS = WIDTH_BITS_DEF;

  // Measurement phases: wait for a rise, then count high ticks, per channel.
  typedef enum logic [1:0] {
    WAIT_CH1 = 2'd0,
    HIGH_CH1 = 2'd1,
    WAIT_CH2 = 2'd2,
    HIGH_CH2 = 2'd3
  } phase_e;

  // One row of the directed table: the pin word, and a hand-written result
  // word where one is easy to read off; otherwise the prediction is used.
  typedef struct {
    in_word_t  pins;
    bit        typed;
    out_word_t want;
  } tick_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;
  logic                cfg_write = 1'b0;
  logic [AGE_BITS-1:0] cfg_data = '0;

  dual_rc_pulse_width_capture u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Capture predictor: own copy of the phase machine, counter and age.
  // ---------------------------------------------------------------------
  phase_e                    cap_phase = WAIT_CH1;
  logic                      last_ch1 = 1'b0;
  logic                      last_ch2 = 1'b0;
  logic [CNT_BITS-1:0]       high_ticks = '0;
  logic [OUT_WIDTH_BITS-1:0] held_ch1 = RESET_WIDTH;
  logic [OUT_WIDTH_BITS-1:0] held_ch2 = RESET_WIDTH;
  logic [AGE_BITS-1:0]       ticks_since_capture = '0;
  logic [AGE_BITS-1:0]       fail_ticks = FAIL_SAFE_RESET;

  // Advance the model by one tick and return the result word it gives.
  function automatic out_word_t predict_capture(in_word_t pins);
    out_word_t res;
    logic      lvl1;
    logic      lvl2;
    logic      done;
    logic      chan;
    lvl1 = pins.ch1_level;
    lvl2 = pins.ch2_level;
    done = 1'b0;
    chan = 1'b0;
    // Only one phase step per tick, so an edge of the other channel that
    // lands on the same tick as a fall is missed.
    case (cap_phase)
      WAIT_CH1: begin
        if (lvl1 && !last_ch1) begin
          high_ticks = CNT_BITS'(1);
          cap_phase  = HIGH_CH1;
        end
      end
      HIGH_CH1: begin
        if (!lvl1 && last_ch1) begin
          held_ch1  = OUT_WIDTH_BITS'(high_ticks);
          done      = 1'b1;
          cap_phase = WAIT_CH2;
        end else if (high_ticks != '1) begin
          high_ticks = high_ticks + 1'b1;
        end
      end
      WAIT_CH2: begin
        if (lvl2 && !last_ch2) begin
          high_ticks = CNT_BITS'(1);
          cap_phase  = HIGH_CH2;
        end
      end
      default: begin
        if (!lvl2 && last_ch2) begin
          held_ch2  = OUT_WIDTH_BITS'(high_ticks);
          done      = 1'b1;
          chan      = 1'b1;
          cap_phase = WAIT_CH1;
        end else if (high_ticks != '1) begin
          high_ticks = high_ticks + 1'b1;
        end
      end
    endcase
    last_ch1 = lvl1;
    last_ch2 = lvl2;
    // Restart the age on every capture, else grow it up to saturation.
    if (done) begin
      ticks_since_capture = '0;
    end else if (ticks_since_capture != AGE_MAX) begin
      ticks_since_capture = ticks_since_capture + 1'b1;
    end
    res.width_ch1    = held_ch1;
    res.width_ch2    = held_ch2;
    res.capture_done = done;
    res.done_channel = chan;
    res.fail_safe    = (ticks_since_capture > fail_ticks);
    return res;
  endfunction

  // Result words still owed by the block, oldest first.
  out_word_t owed_words[$];
  int        mismatches = 0;

  // Idle knobs; the percentages change only between phases of the run.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit send_calm = 1'b0;

  // ---------------------------------------------------------------------
  // Receiver: stall at random, check every accepted result word.
  // ---------------------------------------------------------------------
  bit recv_calm = 1'b0;
  int recv_calm_left = 0;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result word %p", $realtime, out_data);
        end
      end else begin
        want = owed_words.pop_front();
        if (out_data.width_ch1 !== want.width_ch1 ||
            out_data.width_ch2 !== want.width_ch2 ||
            out_data.capture_done !== want.capture_done ||
            out_data.done_channel !== want.done_channel ||
            out_data.fail_safe !== want.fail_safe) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch, expected w1=%0d w2=%0d done=%0b ch=%0b fs=%0b",
                     $realtime, want.width_ch1, want.width_ch2, want.capture_done,
                     want.done_channel, want.fail_safe);
            $display("%0t:                  actual w1=%0d w2=%0d done=%0b ch=%0b fs=%0b",
                     $realtime, out_data.width_ch1, out_data.width_ch2,
                     out_data.capture_done, out_data.done_channel, out_data.fail_safe);
          end
        end
      end
    end
    // Alternate stretches of random stalls with stretches of none.
    if (recv_calm_left == 0) begin
      recv_calm = ($urandom_range(3) == 0);
      recv_calm_left = $urandom_range(80, 20);
    end else begin
      recv_calm_left--;
    end
    out_stall <= !recv_calm && ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------

  // Offer one pin word, hold it until accepted, then log what it owes.
  task automatic send_tick(input in_word_t pins, input bit typed = 1'b0,
                           input out_word_t typed_want = '0);
    out_word_t predicted;
    while (!send_calm && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_capture(pins);
    owed_words.push_back(typed ? typed_want : predicted);
  endtask

  // Drop valid and wait for every owed word, plus the pipeline depth.
  task automatic drain;
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the fail-safe threshold while the block is empty.
  task automatic set_fail_ticks(input logic [AGE_BITS-1:0] ticks);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
    fail_ticks = ticks;
  endtask

  // Random pin traffic: mostly pulse trains where each pin toggles with a
  // random odds per burst, so rises, falls and widths all vary; some bursts
  // are raw noise.
  in_word_t pin_state = '0;

  task automatic send_pulse_trains(input int n_words);
    int sent;
    int burst_len;
    int odds;
    bit noisy;
    in_word_t pins;
    sent = 0;
    while (sent < n_words) begin
      burst_len = $urandom_range(40, 8);
      noisy     = ($urandom_range(4) == 0);
      odds      = $urandom_range(12, 2);
      send_calm = ($urandom_range(3) == 0);
      repeat (burst_len) begin
        if (noisy) begin
          pins = in_word_t'(2'($urandom_range(3)));
        end else begin
          pins = pin_state;
          if ($urandom_range(odds - 1) == 0) pins.ch1_level = ~pins.ch1_level;
          if ($urandom_range(odds - 1) == 0) pins.ch2_level = ~pins.ch2_level;
        end
        pin_state = pins;
        send_tick(pins);
        sent++;
      end
    end
    send_calm = 1'b0;
  endtask

  // Directed table, run from reset with the default threshold. Pins are
  // {ch1_level, ch2_level}; result words are {w1, w2, done, chan, fail}.
  tick_row_t dir_rows[] = '{
    // idle pins right after reset: both widths at their reset value
    '{2'b00, 1'b1, {16'd1500, 16'd1500, 1'b0, 1'b0, 1'b0}},
    // channel 1 rise, nothing latched yet
    '{2'b10, 1'b1, {16'd1500, 16'd1500, 1'b0, 1'b0, 1'b0}},
    '{2'b10, 1'b0, '0},
    // channel 2 high while channel 1 is measured: ignored
    '{2'b11, 1'b0, '0},
    // channel 1 falls while channel 2 stays high: no channel 2 rise to catch
    '{2'b01, 1'b0, '0},
    '{2'b01, 1'b0, '0},
    '{2'b00, 1'b0, '0},
    // channel 2 rise
    '{2'b01, 1'b0, '0},
    // one-tick channel 2 pulse, channel 1 rise on the same tick is missed
    '{2'b10, 1'b1, {16'd3, 16'd1, 1'b1, 1'b1, 1'b0}},
    '{2'b10, 1'b0, '0},
    '{2'b00, 1'b0, '0},
    '{2'b10, 1'b0, '0},
    // one-tick channel 1 pulse, channel 2 rise on the same tick is missed
    '{2'b01, 1'b1, {16'd1, 16'd1, 1'b1, 1'b0, 1'b0}},
    '{2'b00, 1'b0, '0},
    '{2'b01, 1'b0, '0},
    '{2'b11, 1'b0, '0},
    '{2'b11, 1'b0, '0},
    '{2'b00, 1'b0, '0},
    '{2'b11, 1'b0, '0},
    '{2'b00, 1'b0, '0},
    '{2'b11, 1'b0, '0},
    '{2'b00, 1'b0, '0}
  };

  initial begin
    in_word_t pins;
    // Hold reset, then release it once for the whole run.
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the sender and receiver both at full rate.
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].pins, dir_rows[i].typed, dir_rows[i].want);
    end

    // Sender idles lightly, receiver stalls heavily.
    send_idle_pct = 28;
    recv_idle_pct = 86;
    set_fail_ticks('0);              // zero threshold: fails on every idle tick
    send_pulse_trains(125);
    set_fail_ticks(AGE_MAX);         // largest threshold: never fails
    send_pulse_trains(125);

    // Roles swapped.
    send_idle_pct = 86;
    recv_idle_pct = 28;
    set_fail_ticks(24'd1);
    send_pulse_trains(125);
    set_fail_ticks(AGE_BITS'($urandom_range(40, 2)));
    send_pulse_trains(125);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_fail_ticks(AGE_BITS'($urandom_range(AGE_MAX, 1)));
    send_pulse_trains(125);

    // One long channel 1 pulse: let the age pass the threshold before the
    // fall.
    set_fail_ticks(24'd20);
    pins = '0;
    send_tick(pins);
    pins.ch1_level = 1'b1;
    repeat (30) send_tick(pins);
    pins.ch1_level = 1'b0;
    send_tick(pins);
    pin_state = pins;

    set_fail_ticks(AGE_BITS'($urandom_range(30, 1)));
    send_pulse_trains(90);

    // Wait out every owed word and the pipeline, then report.
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/drpwc_pkg.sv
rtl/drpwc_phase.sv
rtl/drpwc_age.sv
rtl/dual_rc_pulse_width_capture.sv
rtl/drpwc_check.sv
tb/dual_rc_pulse_width_capture_tb.sv
